### hw/rtl/cgra_pkg.sv
package cgra_pkg;

    localparam int unsigned FONT_BYTES_DEF = 528384;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam int unsigned ADDR_W = 20;

    localparam logic [2:0] MODE_CODE_HI   = 3'd0;
    localparam logic [2:0] MODE_CODE_LO   = 3'd1;
    localparam logic [2:0] MODE_LINE      = 3'd2;
    localparam logic [2:0] MODE_PAT_WRITE = 3'd3;
    localparam logic [2:0] MODE_PAT_READ  = 3'd4;
    localparam logic [2:0] MODE_PRELOAD   = 3'd5;

    localparam logic CFG_CHIP_LEVEL   = 1'b0;
    localparam logic CFG_DISPLAY_MODE = 1'b1;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [ADDR_W-1:0] WIN_IDLE   = 20'h7fff0;
    localparam logic [ADDR_W-1:0] HALF_BASE  = 20'h80000;
    localparam logic [ADDR_W-1:0] HALF_EXTRA = 20'h02000;
    localparam logic [ADDR_W-1:0] LEFT_OFS   = 20'h00800;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] win_low;
        logic [ADDR_W-1:0] win_high;
        logic [7:0]        win_flags;
    } cgra_entry_t;

endpackage

### hw/rtl/cgra_front.sv
module cgra_front #(
    parameter int unsigned FONT_BYTES = cgra_pkg::FONT_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic                          cfg_index,
    input  logic [1:0]                    cfg_data,
    input  logic                          start,
    input  logic                          full,
    input  logic [2:0]                    mode,
    input  logic [7:0]                    data,
    input  logic [cgra_pkg::ADDR_W-1:0]   load_address,
    output logic                          push,
    output cgra_pkg::cgra_entry_t         entry
);
    import cgra_pkg::*;

    localparam logic [ADDR_W:0] FONT_LIM = (ADDR_W+1)'(FONT_BYTES);

    logic [1:0]        chip_level_reg;
    logic              display_mode_reg;
    logic [15:0]       char_code_reg, char_code_next;
    logic [4:0]        line_reg, line_next;
    logic              left_reg, left_next;
    logic [ADDR_W-1:0] win_low_reg, win_low_next;
    logic [ADDR_W-1:0] win_high_reg, win_high_next;
    logic [7:0]        win_flags_reg, win_flags_next;

    logic [ADDR_W-1:0] calc_lo, calc_hi;
    logic              calc_wr;
    logic [6:0]        cls;
    logic [ADDR_W-1:0] base, half_ofs, cur_base, cur_half;
    logic [ADDR_W-1:0] mem_addr;
    logic [1:0]        mem_op;
    logic              in_range;

    assign push = start && !full;

    // window from the updated code and line
    always_comb
    begin
        cls      = char_code_next[6:0];
        base     = {1'b0, char_code_next[14:8], 1'b0, char_code_next[6:0], 4'h0};
        half_ofs = left_next ? LEFT_OFS : '0;
        calc_lo  = WIN_IDLE;
        calc_hi  = WIN_IDLE;
        calc_wr  = 1'b0;
        if (chip_level_reg >= 2'd2)
        begin
            if (char_code_next[15:8] == 8'h00)
            begin
                calc_hi = HALF_BASE + {8'h00, char_code_next[7:0], 4'h0};
                if (!display_mode_reg)
                begin
                    calc_hi = calc_hi + HALF_EXTRA;
                end
            end
            else if (cls == 7'h56 || cls == 7'h57)
            begin
                calc_wr = 1'b1;
                calc_hi = base + half_ofs;
            end
            else if (cls >= 7'h09 && cls < 7'h0c)
            begin
                calc_hi = left_next ? WIN_IDLE : base;
            end
            else if ((cls >= 7'h0c && cls < 7'h10) || (cls >= 7'h58 && cls < 7'h60))
            begin
                calc_hi = base + half_ofs;
            end
            else
            begin
                calc_lo = base;
                calc_hi = base + LEFT_OFS;
            end
        end
    end

    always_comb
    begin
        char_code_next = char_code_reg;
        line_next      = line_reg;
        left_next      = left_reg;
        win_low_next   = win_low_reg;
        win_high_next  = win_high_reg;
        win_flags_next = win_flags_reg;
        mem_op         = OP_NONE;
        mem_addr       = load_address;
        cur_base       = {1'b0, char_code_reg[14:8], 1'b0, char_code_reg[6:0], 4'h0};
        cur_half       = left_reg ? LEFT_OFS : '0;
        case (mode)
            MODE_CODE_HI:
            begin
                char_code_next = {data, char_code_reg[7:0]};
            end
            MODE_CODE_LO:
            begin
                char_code_next = {char_code_reg[15:8], data};
            end
            MODE_LINE:
            begin
                line_next = data[4:0];
                left_next = !data[5];
            end
            MODE_PAT_WRITE:
            begin
                if (char_code_reg[6:1] == 6'b101011)
                begin
                    mem_op               = OP_WRITE;
                    mem_addr             = cur_base + cur_half + {16'h0000, line_reg[3:0]};
                    win_flags_next[7]    = 1'b1;
                end
            end
            MODE_PAT_READ:
            begin
                if (char_code_reg[7:0] >= 8'h09 && char_code_reg[7:0] < 8'h0c)
                begin
                    if (!left_reg)
                    begin
                        mem_op   = OP_READ;
                        mem_addr = cur_base + {16'h0000, line_reg[3:0]};
                    end
                end
                else if (char_code_reg[15:8] != 8'h00)
                begin
                    mem_op   = OP_READ;
                    mem_addr = cur_base + cur_half + {16'h0000, line_reg[3:0]};
                end
                else if (!line_reg[4])
                begin
                    mem_op   = OP_READ;
                    mem_addr = HALF_BASE + {8'h00, char_code_reg[7:0], 4'h0}
                               + {15'h0000, line_reg};
                end
            end
            MODE_PRELOAD:
            begin
                mem_op = OP_WRITE;
            end
            default:
            begin
            end
        endcase
        if (mode == MODE_CODE_HI || mode == MODE_CODE_LO || mode == MODE_LINE)
        begin
            win_low_next      = calc_lo;
            win_high_next     = calc_hi;
            win_flags_next[0] = calc_wr;
        end
    end

    assign in_range = {1'b0, mem_addr} < FONT_LIM;

    always_comb
    begin
        entry.op        = in_range ? mem_op : OP_NONE;
        entry.addr      = mem_addr;
        entry.wdata     = data;
        entry.win_low   = win_low_next;
        entry.win_high  = win_high_next;
        entry.win_flags = win_flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_level_reg   <= '0;
            display_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_CHIP_LEVEL:   chip_level_reg   <= cfg_data;
                CFG_DISPLAY_MODE: display_mode_reg <= cfg_data[0];
                default:          chip_level_reg   <= chip_level_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_code_reg <= '0;
            line_reg      <= '0;
            left_reg      <= 1'b0;
            win_low_reg   <= WIN_IDLE;
            win_high_reg  <= WIN_IDLE;
            win_flags_reg <= '0;
        end
        else if (push)
        begin
            char_code_reg <= char_code_next;
            line_reg      <= line_next;
            left_reg      <= left_next;
            win_low_reg   <= win_low_next;
            win_high_reg  <= win_high_next;
            win_flags_reg <= win_flags_next;
        end
    end

endmodule

### hw/rtl/cgra_queue.sv
module cgra_queue #(
    parameter int unsigned DEPTH = cgra_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cgra_pkg::cgra_entry_t push_entry,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output cgra_pkg::cgra_entry_t head
);
    import cgra_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cgra_entry_t        slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign head   = slots_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### hw/rtl/cgra_back.sv
module cgra_back #(
    parameter int unsigned FONT_BYTES = cgra_pkg::FONT_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          empty,
    input  cgra_pkg::cgra_entry_t         head,
    output logic                          pop,
    output logic                          done,
    output logic [7:0]                    read_data,
    output logic [cgra_pkg::ADDR_W-1:0]   window_low,
    output logic [cgra_pkg::ADDR_W-1:0]   window_high,
    output logic [7:0]                    window_flags
);
    import cgra_pkg::*;

    localparam int unsigned MEM_AW = $clog2(FONT_BYTES);

    logic [7:0]        font_mem [FONT_BYTES];
    logic [7:0]        mem_q_reg;
    logic              rd_en_reg;
    logic              done_reg;
    logic [ADDR_W-1:0] win_low_reg, win_high_reg;
    logic [7:0]        win_flags_reg;

    assign pop = !empty;

    always_ff @(posedge clk)
    begin
        if (pop && head.op == OP_WRITE)
        begin
            font_mem[head.addr[MEM_AW-1:0]] <= head.wdata;
        end
        if (pop && head.op == OP_READ)
        begin
            mem_q_reg <= font_mem[head.addr[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_en_reg     <= (head.op == OP_READ);
            win_low_reg   <= head.win_low;
            win_high_reg  <= head.win_high;
            win_flags_reg <= head.win_flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pop;
        end
    end

    assign done         = done_reg;
    assign read_data    = rd_en_reg ? mem_q_reg : 8'h00;
    assign window_low   = win_low_reg;
    assign window_high  = win_high_reg;
    assign window_flags = win_flags_reg;

endmodule

### hw/rtl/char_gen_rom_access_ports.sv
// channel   | handshake            | payload
// ----------+----------------------+--------------------------------------------
// access    | start & !busy        | mode, data, load_address
// result    | done (one cycle)     | read_data, window_low, window_high,
//           |                      | window_flags
// config    | cfg_wr               | cfg_index, cfg_data
//
// One transaction per cycle; an accepted transaction enters the queue, then the
// back pops it and registers the result, raising done with it.
// The front decodes and updates the window; the back does the single font
// memory access and registers the result. A two-entry queue sits between them.
// The back pops whenever the queue is not empty, so the queue never fills and busy stays low;
// the receiver cannot stall.
// Reset clears the front, queue and done state; the back's result registers and the font memory are not initialized.
module char_gen_rom_access_ports #(
    parameter int unsigned FONT_BYTES = cgra_pkg::FONT_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic                          cfg_index,
    input  logic [1:0]                    cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    mode,
    input  logic [7:0]                    data,
    input  logic [cgra_pkg::ADDR_W-1:0]   load_address,
    output logic                          done,
    output logic [7:0]                    read_data,
    output logic [cgra_pkg::ADDR_W-1:0]   window_low,
    output logic [cgra_pkg::ADDR_W-1:0]   window_high,
    output logic [7:0]                    window_flags
);
    import cgra_pkg::*;

    logic        push, pop, full, empty;
    cgra_entry_t push_entry, head;

    assign busy = full;

    cgra_front #(
        .FONT_BYTES (FONT_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_wr),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .full         (full),
        .mode         (mode),
        .data         (data),
        .load_address (load_address),
        .push         (push),
        .entry        (push_entry)
    );

    cgra_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .empty      (empty),
        .head       (head)
    );

    cgra_back #(
        .FONT_BYTES (FONT_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .done         (done),
        .read_data    (read_data),
        .window_low   (window_low),
        .window_high  (window_high),
        .window_flags (window_flags)
    );

endmodule

### hw/rtl/cgra_checker.sv
module cgra_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [7:0]  window_flags
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a matching transaction");

    a_flag_bits: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (window_flags[6:1] == 6'b000000))
        else $error("reserved window flag bits set");

    a_user_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && $past(window_flags[7])) |-> window_flags[7])
        else $error("user pattern flag cleared");

endmodule

bind char_gen_rom_access_ports cgra_checker u_cgra_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .window_flags (window_flags)
);

### tb/sv/tb.sv
module tb;

    import cgra_pkg::*;

    localparam int unsigned MAX_CYCLES = 400000;
    localparam int unsigned LAST_ADDR  = FONT_BYTES_DEF - 1;

    typedef struct packed {
        logic [7:0]        rd;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [7:0]        flags;
    } font_result_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              cfg_wr = 1'b0;
    logic              cfg_index = 1'b0;
    logic [1:0]        cfg_data = 2'b00;
    logic              start = 1'b0;
    logic              busy;
    logic [2:0]        mode = MODE_CODE_HI;
    logic [7:0]        data = 8'h00;
    logic [ADDR_W-1:0] load_address = '0;
    logic              done;
    logic [7:0]        read_data;
    logic [ADDR_W-1:0] window_low;
    logic [ADDR_W-1:0] window_high;
    logic [7:0]        window_flags;

    char_gen_rom_access_ports uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_wr),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .data         (data),
        .load_address (load_address),
        .done         (done),
        .read_data    (read_data),
        .window_low   (window_low),
        .window_high  (window_high),
        .window_flags (window_flags)
    );

    // shadow copy of the block state
    logic [1:0]        chip_lvl_m = 2'd0;
    logic              disp_bit_m = 1'b0;
    logic [15:0]       code_m = 16'h0000;
    logic [4:0]        line_m = 5'd0;
    logic              left_m = 1'b0;
    logic [ADDR_W-1:0] win_lo_m = WIN_IDLE;
    logic [ADDR_W-1:0] win_hi_m = WIN_IDLE;
    logic [7:0]        flags_m = 8'h00;
    logic [7:0]        font_mem [int unsigned];

    font_result_t font_results_due [$];

    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned n_items = 0;
    int unsigned n_reads = 0;
    int unsigned n_pat_writes = 0;
    int unsigned n_checked = 0;
    int unsigned n_settings = 0;
    bit          no_idle = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, font_results_due.size());
            $display("tb failed");
            $finish;
        end
    end

    function automatic void recompute_window();
        int unsigned lo;
        int unsigned hi;
        int unsigned c;
        int unsigned ofs;
        lo = 32'(WIN_IDLE);
        hi = lo;
        ofs = left_m ? 32'(LEFT_OFS) : 32'd0;
        flags_m[0] = 1'b0;
        if (chip_lvl_m >= 2'd2)
        begin
            if (code_m[15:8] == 8'h00)
            begin
                hi = 32'(HALF_BASE) + (32'(code_m) << 4);
                if (!disp_bit_m)
                    hi = hi + 32'(HALF_EXTRA);
            end
            else
            begin
                c = 32'(code_m[6:0]);
                hi = 32'(code_m & 16'h7f7f) << 4;
                if (c >= 32'h56 && c < 32'h58)
                begin
                    flags_m[0] = 1'b1;
                    hi = hi + ofs;
                end
                else if (c >= 32'h09 && c < 32'h0c)
                begin
                    if (left_m)
                        hi = lo;
                end
                else if ((c >= 32'h0c && c < 32'h10) || (c >= 32'h58 && c < 32'h60))
                    hi = hi + ofs;
                else
                begin
                    lo = hi;
                    hi = hi + 32'(LEFT_OFS);
                end
            end
        end
        win_lo_m = lo[ADDR_W-1:0];
        win_hi_m = hi[ADDR_W-1:0];
    endfunction

    // returns 1 when a read with the current code/line touches the store
    function automatic bit pattern_addr(output int unsigned a);
        int unsigned base;
        base = 32'(code_m & 16'h7f7f) << 4;
        if (code_m[7:0] >= 8'h09 && code_m[7:0] < 8'h0c)
        begin
            a = base + 32'(line_m[3:0]);
            return !left_m && a < FONT_BYTES_DEF;
        end
        if (code_m[15:8] != 8'h00)
        begin
            a = base + (left_m ? 32'(LEFT_OFS) : 32'd0) + 32'(line_m[3:0]);
            return a < FONT_BYTES_DEF;
        end
        a = 32'(HALF_BASE) + (32'(code_m) << 4) + 32'(line_m);
        return !line_m[4] && a < FONT_BYTES_DEF;
    endfunction

    function automatic void predict_access(logic [2:0] m, logic [7:0] d,
                                           logic [ADDR_W-1:0] la);
        font_result_t r;
        int unsigned  a;
        r.rd = 8'h00;
        case (m)
            MODE_CODE_HI:
            begin
                code_m[15:8] = d;
                recompute_window();
            end
            MODE_CODE_LO:
            begin
                code_m[7:0] = d;
                recompute_window();
            end
            MODE_LINE:
            begin
                line_m = d[4:0];
                left_m = !d[5];
                recompute_window();
            end
            MODE_PAT_WRITE:
            begin
                if ((code_m & 16'h007e) == 16'h0056)
                begin
                    a = (32'(code_m & 16'h7f7f) << 4) +
                        (left_m ? 32'(LEFT_OFS) : 32'd0) + 32'(line_m[3:0]);
                    if (a < FONT_BYTES_DEF)
                        font_mem[a] = d;
                    flags_m[7] = 1'b1;
                    n_pat_writes++;
                end
            end
            MODE_PAT_READ:
            begin
                if (pattern_addr(a))
                    r.rd = font_mem.exists(a) ? font_mem[a] : 8'h00;
                n_reads++;
            end
            MODE_PRELOAD:
            begin
                if (32'(la) < FONT_BYTES_DEF)
                    font_mem[32'(la)] = d;
            end
            default:
            begin
            end
        endcase
        r.lo = win_lo_m;
        r.hi = win_hi_m;
        r.flags = flags_m;
        font_results_due.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(negedge clk)
    begin
        font_result_t w;
        if (rst_n && done === 1'b1)
        begin
            if (font_results_due.size() == 0)
            begin
                $display("%0t: unexpected result: read_data %0h window %0h..%0h flags %0h",
                         $time, read_data, window_low, window_high, window_flags);
                errors++;
            end
            else
            begin
                w = font_results_due.pop_front();
                check_field("read_data", 32'(w.rd), 32'(read_data));
                check_field("window_low", 32'(w.lo), 32'(window_low));
                check_field("window_high", 32'(w.hi), 32'(window_high));
                check_field("window_flags", 32'(w.flags), 32'(window_flags));
                n_checked++;
            end
        end
    end

    task automatic idle_gap();
        int unsigned n;
        int unsigned pick;
        if (no_idle)
            return;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            n = 0;
        else if (pick < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(6, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_access(input logic [2:0] m, input logic [7:0] d,
                               input logic [ADDR_W-1:0] la);
        bit took;
        start <= 1'b1;
        mode <= m;
        data <= d;
        load_address <= la;
        do
        begin
            @(negedge clk);
            took = !busy;
            @(posedge clk);
        end
        while (!took);
        predict_access(m, d, la);
        n_items++;
        idle_gap();
    endtask

    function automatic logic [ADDR_W-1:0] rand_load_addr();
        return ADDR_W'($urandom_range(0, LAST_ADDR));
    endfunction

    // fills the addressed byte first if it was never written
    task automatic read_pattern();
        int unsigned a;
        if (pattern_addr(a) && !font_mem.exists(a))
            send_access(MODE_PRELOAD, 8'($urandom), ADDR_W'(a));
        send_access(MODE_PAT_READ, 8'($urandom), rand_load_addr());
    endtask

    task automatic drain();
        start <= 1'b0;
        while (font_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_levels(input logic [1:0] chip, input logic disp);
        drain();
        cfg_wr <= 1'b1;
        cfg_index <= CFG_CHIP_LEVEL;
        cfg_data <= chip;
        @(posedge clk);
        cfg_index <= CFG_DISPLAY_MODE;
        cfg_data <= {1'($urandom), disp};
        @(posedge clk);
        cfg_wr <= 1'b0;
        @(posedge clk);
        chip_lvl_m = chip;
        disp_bit_m = disp;
        n_settings++;
    endtask

    task automatic test_directed();
        read_pattern();
        set_levels(2'd3, 1'b0);
        send_access(MODE_CODE_LO, 8'hff, '0);
        send_access(MODE_LINE, 8'h1f, '0);
        read_pattern();
        send_access(MODE_CODE_HI, 8'hff, rand_load_addr());
        send_access(MODE_CODE_LO, 8'h56, '0);
        send_access(MODE_LINE, 8'h20, '0);
        send_access(MODE_PAT_WRITE, 8'ha5, '0);
        read_pattern();
        send_access(MODE_LINE, 8'h0f, '0);
        send_access(MODE_PAT_WRITE, 8'h5a, '0);
        read_pattern();
        send_access(MODE_CODE_LO, 8'h58, '0);
        send_access(MODE_PAT_WRITE, 8'h3c, '0);
        send_access(MODE_CODE_LO, 8'h0a, '0);
        send_access(MODE_LINE, 8'h00, '0);
        read_pattern();
        send_access(MODE_LINE, 8'he3, '0);
        read_pattern();
        // window holds until the next code or line write
        set_levels(2'd1, 1'b1);
        send_access(MODE_PRELOAD, 8'hff, ADDR_W'(LAST_ADDR));
        send_access(MODE_PRELOAD, 8'h00, '0);
        send_access(MODE_CODE_HI, 8'h00, '0);
        set_levels(2'd2, 1'b1);
        send_access(MODE_CODE_LO, 8'h0d, '0);
        send_access(MODE_CODE_HI, 8'h21, '0);
    endtask

    function automatic logic [7:0] pick_code_hi();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'($urandom_range(1, 255));
            2: return 8'($urandom);
            default: return 8'($urandom_range(8'h21, 8'h7f)) | {1'($urandom), 7'h00};
        endcase
    endfunction

    function automatic logic [7:0] pick_code_lo();
        logic [7:0] top;
        top = {1'($urandom), 7'h00};
        case ($urandom_range(0, 5))
            0: return top | 8'($urandom_range(8'h56, 8'h57));
            1: return top | 8'($urandom_range(8'h09, 8'h0b));
            2: return top | 8'($urandom_range(8'h0c, 8'h0f));
            3: return top | 8'($urandom_range(8'h58, 8'h5f));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic pattern_sequence();
        int unsigned a;
        int unsigned k;
        send_access(MODE_CODE_HI, pick_code_hi(), rand_load_addr());
        send_access(MODE_CODE_LO, pick_code_lo(), rand_load_addr());
        send_access(MODE_LINE, 8'($urandom), rand_load_addr());
        k = $urandom_range(1, 6);
        repeat (k)
        begin
            case ($urandom_range(0, 5))
                0, 1: send_access(MODE_PAT_WRITE, 8'($urandom), rand_load_addr());
                2: read_pattern();
                3: send_access(MODE_LINE, 8'($urandom), rand_load_addr());
                4:
                begin
                    if (pattern_addr(a))
                        send_access(MODE_PRELOAD, 8'($urandom), ADDR_W'(a));
                    read_pattern();
                end
                default: send_access(MODE_PRELOAD, 8'($urandom), rand_load_addr());
            endcase
        end
    endtask

    task automatic noise_access();
        logic [2:0] m;
        m = 3'($urandom_range(MODE_CODE_HI, MODE_PRELOAD));
        if (m == MODE_PAT_READ)
            read_pattern();
        else
            send_access(m, 8'($urandom), rand_load_addr());
    endtask

    task automatic test_random_phases();
        logic [1:0] chips [8];
        logic       disps [8];
        int unsigned target;
        chips = '{2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'($urandom), 2'($urandom)};
        disps = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'($urandom), 1'($urandom)};
        for (int p = 0; p < 8; p++)
        begin
            set_levels(chips[p], disps[p]);
            target = n_items + 200;
            while (n_items < target)
            begin
                no_idle = ($urandom_range(0, 5) == 0);
                if ($urandom_range(0, 9) < 7)
                    pattern_sequence();
                else
                    noise_access();
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phases();
        drain();
        repeat (10) @(posedge clk);
        $display("Ran %0d transactions across %0d register settings: %0d pattern reads,",
                 n_items, n_settings, n_reads);
        $display("%0d accepted pattern writes, %0d results checked, %0d errors.",
                 n_pat_writes, n_checked, errors);
        if (errors == 0 && font_results_due.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

### char_gen_rom_access_ports.f
hw/rtl/cgra_pkg.sv
hw/rtl/cgra_front.sv
hw/rtl/cgra_queue.sv
hw/rtl/cgra_back.sv
hw/rtl/char_gen_rom_access_ports.sv
hw/rtl/cgra_checker.sv
tb/sv/tb.sv
